[hw/rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int BLOCK_COUNT_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int IN_IDX_W        = 6;
  localparam int RES_IDX_W       = 6;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_LIST  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_LIST,
    S_LIST_END
  } state_t;

endpackage

[hw/rtl/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/fixed_block_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// pool of equal blocks kept as a linked free list, allocate, free and list
// ----------------------------------------------------------------------------
// Each block has one entry in a single link memory holding its allocated mark
// and its free-list link; the list head and a fill count live in registers.
// Blocks at or above the fill count have never been handed out, so their
// entries read as "free, links to the next index" without being written, and
// no clearing pass follows reset. For allocate and free, the transfer cycle
// issues the read of the link memory; S_ALLOC or S_FREE then writes the entry
// back on success and loads the result register once that register is free. A
// list issues one link memory read per block between its start and end states
// and is held while the result register stays stalled. One item is worked at a
// time; the result register lets the next item in while a result waits.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [IN_IDX_W-1:0]  in_block_index,
  input  logic                 in_include_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RES_IDX_W-1:0] out_result_index,
  output logic [1:0]           out_status,
  output logic                 out_last
);

  localparam int IDX_W  = $clog2(BLOCK_COUNT);
  localparam int LINK_W = $clog2(BLOCK_COUNT + 1);
  localparam int ENT_W  = LINK_W + 1;
  localparam int CMP_W  = (LINK_W > IN_IDX_W) ? LINK_W : IN_IDX_W;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(BLOCK_COUNT);

  state_t               state_r, state_nxt;
  logic [LINK_W-1:0]    head_r, head_nxt;
  logic [LINK_W-1:0]    fill_r, fill_nxt;
  logic [IN_IDX_W-1:0]  bidx_r, bidx_nxt;
  logic                 incl_r, incl_nxt;
  logic [LINK_W-1:0]    iss_r, iss_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RES_IDX_W-1:0] out_idx_r;
  status_t              out_status_r;
  logic                 out_last_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic [CMP_W-1:0]     ld_idx;
  status_t              ld_status;
  logic                 ld_last;
  logic [CMP_W-1:0]     in_bidx_w;
  logic [CMP_W-1:0]     bidx_w;
  logic                 bidx_in_range;
  logic                 rd_mark;
  logic [LINK_W-1:0]    rd_link;
  logic                 fresh;
  logic [LINK_W-1:0]    alloc_link;
  logic                 free_mark;
  logic                 chk_mark;
  logic                 qual;
  logic                 advance;
  logic                 stop;
  logic [CNT_W-1:0]     cnt_inc;

  fbpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BLOCK_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_bidx_w     = CMP_W'(in_block_index);
  assign bidx_w        = CMP_W'(bidx_r);
  assign bidx_in_range = (bidx_w < CMP_W'(BLOCK_COUNT));
  assign rd_mark       = ram_rdata[ENT_W-1];
  assign rd_link       = ram_rdata[LINK_W-1:0];
  assign fresh         = (head_r >= fill_r);
  assign alloc_link    = fresh ? (head_r + LINK_W'(1)) : rd_link;
  assign free_mark     = (bidx_w < CMP_W'(fill_r)) && rd_mark;
  assign chk_mark      = (LINK_W'(chk_idx_r) < fill_r) && rd_mark;
  assign qual          = chk_v_r && (incl_r || chk_mark);
  assign advance       = !qual || !pend_v_r || out_free;
  assign cnt_inc       = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      chk_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      chk_v_r     <= chk_v_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r     <= bidx_nxt;
    incl_r     <= incl_nxt;
    iss_r      <= iss_nxt;
    chk_idx_r  <= chk_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (out_load) begin
      out_idx_r    <= ld_idx[RES_IDX_W-1:0];
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    bidx_nxt     = bidx_r;
    incl_nxt     = incl_r;
    iss_nxt      = iss_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    cnt_nxt      = cnt_r;
    ram_re       = 1'b0;
    ram_raddr    = head_r[IDX_W-1:0];
    ram_we       = 1'b0;
    ram_waddr    = head_r[IDX_W-1:0];
    ram_wdata    = '0;
    out_load     = 1'b0;
    ld_idx       = '0;
    ld_status    = ST_OK;
    ld_last      = 1'b1;
    stop         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority case (func_t'(in_func))
            FUNC_ALLOC: begin
              ram_re    = 1'b1;
              ram_raddr = head_r[IDX_W-1:0];
              state_nxt = S_ALLOC;
            end
            FUNC_FREE: begin
              bidx_nxt  = in_block_index;
              ram_re    = 1'b1;
              ram_raddr = in_bidx_w[IDX_W-1:0];
              state_nxt = S_FREE;
            end
            FUNC_LIST: begin
              incl_nxt   = in_include_free;
              iss_nxt    = '0;
              chk_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              cnt_nxt    = '0;
              state_nxt  = S_LIST;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (head_r == END_MARK) begin
            ld_status = ST_EMPTY;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_r[IDX_W-1:0];
            ram_wdata = {1'b1, alloc_link};
            head_nxt  = alloc_link;
            ld_idx    = CMP_W'(head_r);
            if (fresh) begin
              fill_nxt = head_r + LINK_W'(1);
            end
          end
        end
      end

      S_FREE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_idx    = bidx_w;
          state_nxt = S_IDLE;
          if (bidx_in_range && free_mark) begin
            ram_we    = 1'b1;
            ram_waddr = bidx_w[IDX_W-1:0];
            ram_wdata = {1'b0, head_r};
            head_nxt  = bidx_w[LINK_W-1:0];
          end else begin
            ld_status = ST_NOT_ALLOC;
          end
        end
      end

      S_LIST: begin
        if (advance) begin
          if (qual) begin
            if (pend_v_r) begin
              out_load = 1'b1;
              ld_idx   = CMP_W'(pend_idx_r);
              ld_last  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = chk_idx_r;
            cnt_nxt      = cnt_inc;
            stop         = (cnt_inc == CNT_W'(MAX_RESULTS));
          end
          if (!stop && (iss_r < END_MARK)) begin
            ram_re      = 1'b1;
            ram_raddr   = iss_r[IDX_W-1:0];
            iss_nxt     = iss_r + LINK_W'(1);
            chk_v_nxt   = 1'b1;
            chk_idx_nxt = iss_r[IDX_W-1:0];
          end else begin
            chk_v_nxt = 1'b0;
            state_nxt = S_LIST_END;
          end
        end
      end

      S_LIST_END: begin
        if (out_free) begin
          out_load   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
          if (pend_v_r) begin
            ld_idx = CMP_W'(pend_idx_r);
          end else begin
            ld_status = ST_NONE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // head stays in range
  assert property (@(posedge clk) disable iff (!rst_n) head_r <= END_MARK)
    else $error("free list head out of range");

  // a head above the fill count is the fill count itself or the end mark
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r >= fill_r) |-> (head_r == fill_r || head_r == END_MARK))
    else $error("free list head skipped unused blocks");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n) out_load |-> out_free)
    else $error("result register overwritten while stalled");

  // the link memory is never written during a list walk
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST || state_r == S_LIST_END) |-> !ram_we)
    else $error("link memory written during list");

  // list result count stays within the limit
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("list result count over limit");

endmodule

[tb/sv/tb_fixed_block_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_unit
// self-checking bench for the fixed block pool allocator
// ----------------------------------------------------------------------------
// Drives allocate, free and list requests through the valid/stall input port
// while the result port stalls on its own random pattern. A behavioral model
// of the free list, the per-block allocated marks and the list walk predicts
// every result, and each result transfer is compared field by field with the
// oldest prediction. Directed cases cover the double-free, unused-code and
// empty-list corners; a full exhaust-and-release pass that also meets the empty
// pool and a long random mix of fill and drain phases follow.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_unit;
  import fbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = BLOCK_COUNT_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [RES_IDX_W-1:0] idx;
    status_t              status;
    logic                 last;
  } blk_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func = FUNC_ALLOC;
  logic [IN_IDX_W-1:0]  in_block_index = '0;
  logic                 in_include_free = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [RES_IDX_W-1:0] out_result_index;
  logic [1:0]           out_status;
  logic                 out_last;

  // free list model
  logic [6:0]  pool_head;
  logic [6:0]  link_mem [NBLK];
  bit          held [NBLK];
  blk_result_t pending_q [$];

  int errors = 0;
  int n_alloc = 0;
  int n_free = 0;
  int n_list = 0;
  int n_ignored = 0;
  int n_checked = 0;
  bit pace_on = 1'b1;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_cyc = 0;

  fixed_block_pool_allocator_unit #(.BLOCK_COUNT(NBLK)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_block_index   (in_block_index),
    .in_include_free  (in_include_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  function automatic void reset_pool();
    pool_head = '0;
    for (int i = 0; i < NBLK; i++) begin
      link_mem[i] = 7'(i + 1);
      held[i] = 1'b0;
    end
    pending_q.delete();
  endfunction

  function automatic void push_expect(logic [RES_IDX_W-1:0] idx, status_t st, logic lst);
    blk_result_t r;
    r.idx = idx;
    r.status = st;
    r.last = lst;
    pending_q.push_back(r);
  endfunction

  function automatic void predict_pool(logic [1:0] f, logic [IN_IDX_W-1:0] b, logic incl);
    logic [6:0] h;
    int hits [$];
    case (f)
      FUNC_ALLOC: begin
        h = pool_head;
        if (h >= NBLK) begin
          push_expect('0, ST_EMPTY, 1'b1);
        end else begin
          pool_head = link_mem[h];
          held[h] = 1'b1;
          push_expect(h[RES_IDX_W-1:0], ST_OK, 1'b1);
        end
      end
      FUNC_FREE: begin
        if (int'(b) >= NBLK || !held[b]) begin
          push_expect(b, ST_NOT_ALLOC, 1'b1);
        end else begin
          link_mem[b] = pool_head;
          pool_head = 7'(b);
          held[b] = 1'b0;
          push_expect(b, ST_OK, 1'b1);
        end
      end
      FUNC_LIST: begin
        for (int i = 0; i < NBLK; i++) begin
          if ((incl || held[i]) && hits.size() < MAX_RESULTS) hits.push_back(i);
        end
        if (hits.size() == 0) begin
          push_expect('0, ST_NONE, 1'b1);
        end else begin
          foreach (hits[k]) begin
            push_expect(RES_IDX_W'(hits[k]), ST_OK, k == hits.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // one transfer on the input port; valid stays high afterwards
  task automatic send_item(logic [1:0] f, logic [IN_IDX_W-1:0] b, logic incl);
    int gap;
    if (pace_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_block_index <= b;
    in_include_free <= incl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pool(f, b, incl);
    case (f)
      FUNC_ALLOC: n_alloc++;
      FUNC_FREE:  n_free++;
      FUNC_LIST:  n_list++;
      default:    n_ignored++;
    endcase
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  function automatic int pick_held();
    int idx [$];
    for (int i = 0; i < NBLK; i++) begin
      if (held[i]) idx.push_back(i);
    end
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  task automatic test_directed();
    pace_on = 1'b1;
    send_item(FUNC_LIST, '0, 1'b0);
    send_item(FUNC_ALLOC, '1, 1'b1);
    send_item(FUNC_ALLOC, '0, 1'b0);
    send_item(FUNC_FREE, 6'd1, 1'b0);
    send_item(FUNC_FREE, 6'd1, 1'b1);
    send_item(FUNC_FREE, '1, 1'b0);
    send_item(FUNC_ALLOC, '0, 1'b0);
    send_item(FUNC_FREE, 6'd0, 1'b0);
    send_item(FUNC_ALLOC, '0, 1'b0);
    send_item(FUNC_UNUSED, '1, 1'b1);
    send_item(FUNC_LIST, '0, 1'b0);
    send_item(FUNC_LIST, '1, 1'b1);
    send_item(FUNC_FREE, 6'd0, 1'b1);
    send_item(FUNC_FREE, 6'd1, 1'b0);
    send_item(FUNC_LIST, '1, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_exhaust_and_release();
    int order [NBLK];
    int j;
    int t;
    pace_on = 1'b0;
    for (int i = 0; i < NBLK + 2; i++) send_item(FUNC_ALLOC, 6'($urandom), 1'($urandom));
    pace_on = 1'b1;
    send_item(FUNC_LIST, '0, 1'b0);
    send_item(FUNC_LIST, '0, 1'b1);
    for (int i = 0; i < NBLK; i++) order[i] = i;
    for (int i = NBLK - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NBLK; i++) send_item(FUNC_FREE, 6'(order[i]), 1'($urandom));
    send_item(FUNC_LIST, '0, 1'b0);
    for (int i = 0; i < 4; i++) send_item(FUNC_ALLOC, '0, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int n_items);
    int done;
    int roll;
    int blk;
    int phase_left;
    bit fill_phase;
    done = 0;
    phase_left = 0;
    fill_phase = 1'b1;
    while (done < n_items) begin
      if (phase_left == 0) begin
        fill_phase = ~fill_phase;
        phase_left = $urandom_range(20, 70);
        pace_on = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(FUNC_UNUSED, 6'($urandom), 1'($urandom));
        continue;
      end
      if (roll < 10) begin
        send_item(FUNC_LIST, 6'($urandom), 1'($urandom));
      end else if (roll < 18) begin
        send_item(FUNC_FREE, 6'($urandom), 1'($urandom));
      end else if ((fill_phase && roll < 78) || (!fill_phase && roll < 35)) begin
        send_item(FUNC_ALLOC, 6'($urandom), 1'($urandom));
      end else begin
        blk = pick_held();
        if (blk < 0) send_item(FUNC_ALLOC, 6'($urandom), 1'($urandom));
        else send_item(FUNC_FREE, 6'(blk), 1'($urandom));
      end
      done++;
      if (done == n_items / 2) wait_for_drain();
    end
    wait_for_drain();
    send_item(FUNC_LIST, '0, 1'b1);
  endtask

  // result port stall pattern
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_cyc % 9) < 4;
    endcase
  end

  always @(posedge clk) begin : check_results
    blk_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result index=%0d status=%0d last=%0b",
                             out_result_index, out_status, out_last));
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (out_result_index !== want.idx || out_status !== want.status ||
            out_last !== want.last) begin
          note_error($sformatf(
            {"result mismatch: exp index=%0d status=%0d last=%0b, ",
             "got index=%0d status=%0d last=%0b"},
            want.idx, want.status, want.last, out_result_index, out_status, out_last));
        end
      end
    end
  end

  initial begin
    reset_pool();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_exhaust_and_release();
    test_random_traffic(300);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (NBLK + 10) @(posedge clk);
    if (pending_q.size() != 0) begin
      note_error($sformatf("%0d results never arrived", pending_q.size()));
    end
    $display("covered %0d allocate, %0d free, %0d list and %0d unused-code requests",
             n_alloc, n_free, n_list, n_ignored);
    $display("%0d result transfers compared, %0d failures", n_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
